// ----- rtl/core/hdls_pkg.sv -----
// Shared types and constants for the Hensel limb divider.
`default_nettype none

package hdls_pkg;

    localparam int unsigned LIMB_WIDTH_DEF  = 64;
    localparam int unsigned FIELD_WIDTH     = 64;
    localparam int unsigned SHIFT_WIDTH     = 6;
    localparam int unsigned CFG_INDEX_WIDTH = 1;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIVISOR = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHIFT   = 1'b1;

    // Newton rounds for the 2-adic inverse, partial products per multiply
    localparam int unsigned INV_ROUNDS = 5;
    localparam int unsigned MUL_STEPS  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INV_D,
        ST_INV_T,
        ST_QUOT,
        ST_HIGH,
        ST_EMIT_MERGE,
        ST_EMIT_FINAL
    } hdls_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/hensel_divide_limb_shift.sv -----
// Hensel (2-adic) divider of a multi-limb number by an odd limb, shifted quotient.
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall): one dividend limb per item, least
//   significant first. first_limb opens an operand and brings carry_in as the
//   starting high value; final_limb closes it.
//   Output channel (out_valid / out_stall): quotient limbs shifted right by
//   shift_amount, one limb late. A final limb yields the merged limb (if a run
//   was open) and then the last limb with the remainder and last_of_run set.
//   Config port: cfg_write_en / cfg_index / cfg_data, no wait state. Writing
//   the divisor forces bit 0 high and recomputes its inverse with five Newton
//   rounds (ten multiplies) while in_stall is held high.
// Timing
//   All products run through one shared HxH multiplier (H = half a limb),
//   four partial products accumulated per product. A limb needs two
//   dependent products (quotient, then high part), then up to two results;
//   no new item is taken until the last is through. in_stall is high from
//   accept until the last result of the item sits in the output register,
//   or until the second product ends for an item that yields nothing.
// Reset
//   Divisor 1, inverse 1, shift 0, no run open, output register empty.
// Back-pressure
//   The output register holds its item while out_stall is high; the block
//   waits in its result state until the register frees up.
module hensel_divide_limb_shift
    import hdls_pkg::*;
#(
    parameter int unsigned LIMB_WIDTH = LIMB_WIDTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       cfg_write_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [FIELD_WIDTH-1:0]     cfg_data,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [FIELD_WIDTH-1:0]     dividend_limb,
    input  wire logic [FIELD_WIDTH-1:0]     carry_in,
    input  wire logic                       first_limb,
    input  wire logic                       final_limb,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [FIELD_WIDTH-1:0]          quotient_limb,
    output logic [FIELD_WIDTH-1:0]          remainder,
    output logic                            last_of_run
);

    localparam int unsigned LW     = LIMB_WIDTH;
    localparam int unsigned H      = (LIMB_WIDTH + 1) / 2;
    localparam int unsigned OPW    = 2 * H;
    localparam int unsigned ACCW   = 4 * H;
    localparam logic [SHIFT_WIDTH-1:0] S_MAX = SHIFT_WIDTH'(LIMB_WIDTH - 1);

    hdls_state_t            state_reg, state_next;

    // shared multiplier
    logic [OPW-1:0]         op_a_reg, op_a_next;
    logic [OPW-1:0]         op_b_reg, op_b_next;
    logic [2:0]             mul_cnt_reg, mul_cnt_next;
    logic [OPW-1:0]         pp_reg, pp_next;
    logic [1:0]             pp_pos_reg, pp_pos_next;
    logic [ACCW-1:0]        acc_reg, acc_next;
    logic [2:0]             iter_reg, iter_next;

    // configuration and running state
    logic [LW-1:0]          divisor_reg, divisor_next;
    logic [LW-1:0]          inverse_reg, inverse_next;
    logic [SHIFT_WIDTH-1:0] shift_amount_reg, shift_amount_next;
    logic [LW-1:0]          running_high_reg, running_high_next;
    logic                   borrow_reg, borrow_next;
    logic [LW-1:0]          pending_reg, pending_next;
    logic [LW-1:0]          quot_reg, quot_next;
    logic                   had_open_reg, had_open_next;
    logic                   final_reg, final_next;
    logic                   run_open_reg, run_open_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [LW-1:0]          out_quot_reg, out_quot_next;
    logic [LW-1:0]          out_rem_reg, out_rem_next;
    logic                   out_last_reg, out_last_next;

    logic [H-1:0]           mul_a_half;
    logic [H-1:0]           mul_b_half;
    logic [ACCW-1:0]        pp_aligned;
    logic [ACCW-1:0]        acc_sum;
    logic                   mul_done;
    logic                   accept;
    logic                   out_free;
    logic                   div_write;
    logic                   open_now;
    logic [LW-1:0]          x_val;
    logic [LW-1:0]          rh_val;
    logic [LW-1:0]          t_val;
    logic [LW-1:0]          new_divisor;
    logic [SHIFT_WIDTH-1:0] s_eff;

    assign div_write = cfg_write_en && (cfg_index == CFG_DIVISOR);
    assign in_stall  = (state_reg != ST_IDLE) || div_write;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // partial product select: cnt[0] picks the half of a, cnt[1] the half of b
    assign mul_a_half = mul_cnt_reg[0] ? op_a_reg[OPW-1:H] : op_a_reg[H-1:0];
    assign mul_b_half = mul_cnt_reg[1] ? op_b_reg[OPW-1:H] : op_b_reg[H-1:0];
    assign mul_done   = (mul_cnt_reg == 3'(MUL_STEPS));

    always_comb
    begin
        case (pp_pos_reg)
            2'd0:    pp_aligned = ACCW'(pp_reg);
            2'd1:    pp_aligned = ACCW'(pp_reg) << H;
            2'd2:    pp_aligned = ACCW'(pp_reg) << (2 * H);
            default: pp_aligned = '0;
        endcase
    end

    assign acc_sum = acc_reg + pp_aligned;

    // limb front end
    assign open_now    = run_open_reg && !first_limb;
    assign x_val       = dividend_limb[LW-1:0];
    assign rh_val      = open_now ? running_high_reg : carry_in[LW-1:0];
    assign t_val       = rh_val + LW'(open_now && borrow_reg);
    assign new_divisor = cfg_data[LW-1:0] | LW'(1);
    assign s_eff       = (shift_amount_reg > S_MAX) ? S_MAX : shift_amount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mul_cnt_reg      <= '0;
            iter_reg         <= '0;
            divisor_reg      <= LW'(1);
            inverse_reg      <= LW'(1);
            shift_amount_reg <= '0;
            running_high_reg <= '0;
            borrow_reg       <= 1'b0;
            pending_reg      <= '0;
            had_open_reg     <= 1'b0;
            final_reg        <= 1'b0;
            run_open_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mul_cnt_reg      <= mul_cnt_next;
            iter_reg         <= iter_next;
            divisor_reg      <= divisor_next;
            inverse_reg      <= inverse_next;
            shift_amount_reg <= shift_amount_next;
            running_high_reg <= running_high_next;
            borrow_reg       <= borrow_next;
            pending_reg      <= pending_next;
            had_open_reg     <= had_open_next;
            final_reg        <= final_next;
            run_open_reg     <= run_open_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        pp_reg       <= pp_next;
        pp_pos_reg   <= pp_pos_next;
        acc_reg      <= acc_next;
        quot_reg     <= quot_next;
        out_quot_reg <= out_quot_next;
        out_rem_reg  <= out_rem_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        op_a_next         = op_a_reg;
        op_b_next         = op_b_reg;
        mul_cnt_next      = mul_cnt_reg;
        pp_next           = OPW'(mul_a_half) * OPW'(mul_b_half);
        pp_pos_next       = {1'b0, mul_cnt_reg[0]} + {1'b0, mul_cnt_reg[1]};
        acc_next          = acc_reg;
        iter_next         = iter_reg;
        divisor_next      = divisor_reg;
        inverse_next      = inverse_reg;
        shift_amount_next = shift_amount_reg;
        running_high_next = running_high_reg;
        borrow_next       = borrow_reg;
        pending_next      = pending_reg;
        quot_next         = quot_reg;
        had_open_next     = had_open_reg;
        final_next        = final_reg;
        run_open_next     = run_open_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_quot_next     = out_quot_reg;
        out_rem_next      = out_rem_reg;
        out_last_next     = out_last_reg;

        // multiply states step the shared unit; first cycle only loads pp
        if (state_reg == ST_INV_D || state_reg == ST_INV_T ||
            state_reg == ST_QUOT || state_reg == ST_HIGH)
        begin
            mul_cnt_next = mul_cnt_reg + 3'd1;
            if (mul_cnt_reg != 3'd0)
            begin
                acc_next = acc_sum;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    borrow_next   = (t_val > x_val);
                    had_open_next = open_now;
                    final_next    = final_limb;
                    op_a_next     = OPW'(x_val - t_val);
                    op_b_next     = OPW'(inverse_reg);
                    mul_cnt_next  = '0;
                    acc_next      = '0;
                    state_next    = ST_QUOT;
                end
            end

            ST_INV_D:
            begin
                // t = 2 - d * inv
                if (mul_done)
                begin
                    op_a_next    = OPW'(inverse_reg);
                    op_b_next    = OPW'(LW'(2) - acc_sum[LW-1:0]);
                    mul_cnt_next = '0;
                    acc_next     = '0;
                    state_next   = ST_INV_T;
                end
            end

            ST_INV_T:
            begin
                // inv = inv * t
                if (mul_done)
                begin
                    inverse_next = acc_sum[LW-1:0];
                    iter_next    = iter_reg + 3'd1;
                    op_a_next    = OPW'(divisor_reg);
                    op_b_next    = OPW'(acc_sum[LW-1:0]);
                    mul_cnt_next = '0;
                    acc_next     = '0;
                    if (iter_reg == 3'(INV_ROUNDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_INV_D;
                    end
                end
            end

            ST_QUOT:
            begin
                if (mul_done)
                begin
                    quot_next    = acc_sum[LW-1:0];
                    op_a_next    = OPW'(acc_sum[LW-1:0]);
                    op_b_next    = OPW'(divisor_reg);
                    mul_cnt_next = '0;
                    acc_next     = '0;
                    state_next   = ST_HIGH;
                end
            end

            ST_HIGH:
            begin
                if (mul_done)
                begin
                    running_high_next = acc_sum[2*LW-1:LW];
                    run_open_next     = !final_reg;
                    // with a run open, pending is kept until the merged limb leaves
                    if (had_open_reg)
                    begin
                        state_next = ST_EMIT_MERGE;
                    end
                    else if (final_reg)
                    begin
                        pending_next = quot_reg >> s_eff;
                        state_next   = ST_EMIT_FINAL;
                    end
                    else
                    begin
                        pending_next = quot_reg >> s_eff;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_EMIT_MERGE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_quot_next  = pending_reg
                                   | ((quot_reg << (S_MAX - s_eff)) << 1);
                    out_rem_next   = '0;
                    out_last_next  = 1'b0;
                    pending_next   = quot_reg >> s_eff;
                    state_next     = final_reg ? ST_EMIT_FINAL : ST_IDLE;
                end
                else
                begin
                    out_quot_next = out_quot_reg;
                end
            end

            ST_EMIT_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_quot_next  = pending_reg;
                    out_rem_next   = running_high_reg + LW'(borrow_reg);
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write_en && cfg_index == CFG_SHIFT)
        begin
            shift_amount_next = cfg_data[SHIFT_WIDTH-1:0];
        end

        if (div_write)
        begin
            divisor_next = new_divisor;
            inverse_next = new_divisor;
            iter_next    = '0;
            op_a_next    = OPW'(new_divisor);
            op_b_next    = OPW'(new_divisor);
            mul_cnt_next = '0;
            acc_next     = '0;
            state_next   = ST_INV_D;
        end
    end

    assign out_valid     = out_valid_reg;
    assign quotient_limb = FIELD_WIDTH'(out_quot_reg);
    assign remainder     = FIELD_WIDTH'(out_rem_reg);
    assign last_of_run   = out_last_reg;

endmodule

`default_nettype wire
